// ===== src/assert_macros.svh =====
// Assertion macros used by the SPS parser controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// SPS parser package
// Syntax element phases, status codes, element sizes and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sps_pkg;

  typedef enum logic [5:0] {
    P_NAL, P_PROFILE, P_CONSTR, P_LEVEL, P_ID, P_CHROMA, P_SEPPLANE, P_LUMA_BD,
    P_CHROMA_BD, P_BYPASS, P_SCAL_PRESENT, P_SCAL_FLAG, P_LOG2_FN, P_POC_TYPE,
    P_LOG2_POC, P_DELTA_ZERO, P_OFF_NONREF, P_OFF_TB, P_NUM_CYCLE, P_CYCLE_OFF,
    P_MAX_REF, P_GAPS, P_WIDTH, P_HEIGHT, P_FRAME_MBS, P_MBAFF, P_DIRECT8,
    P_CROP_FLAG, P_CROP_L, P_CROP_R, P_CROP_T, P_CROP_B, P_VUI, P_AR_PRESENT,
    P_AR_IDC, P_SAR_W, P_SAR_H, P_OVERSCAN, P_OVERSCAN_APP, P_VSIG, P_VFORMAT,
    P_FULLRANGE, P_COLDESC, P_COLOUR, P_CHROMA_LOC, P_LOC_TOP, P_LOC_BOT,
    P_TIMING, P_NUIT, P_TS, P_FIXED, P_DONE
  } phase_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TRUNC   = 3'd1;
  localparam logic [2:0] ST_NOT_SPS = 3'd2;
  localparam logic [2:0] ST_SCALING = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  localparam logic [7:0] NAL_TYPE_SPS = 8'd7;
  localparam logic [7:0] AR_EXTENDED  = 8'd255;

  typedef struct packed {
    logic       load;
    logic       bit_en;
    logic [2:0] bit_idx;
    logic       calc;
    logic       clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

  function automatic logic [5:0] elem_bits(input phase_t p);
    logic [5:0] n;
    n = 6'd0;
    case (p)
      P_NAL, P_PROFILE, P_CONSTR, P_LEVEL, P_AR_IDC: n = 6'd8;
      P_SEPPLANE, P_BYPASS, P_SCAL_PRESENT, P_SCAL_FLAG, P_DELTA_ZERO, P_GAPS,
      P_FRAME_MBS, P_MBAFF, P_DIRECT8, P_CROP_FLAG, P_VUI, P_AR_PRESENT,
      P_OVERSCAN, P_OVERSCAN_APP, P_VSIG, P_FULLRANGE, P_COLDESC, P_CHROMA_LOC,
      P_TIMING, P_FIXED: n = 6'd1;
      P_SAR_W, P_SAR_H: n = 6'd16;
      P_VFORMAT: n = 6'd3;
      P_COLOUR: n = 6'd24;
      P_NUIT, P_TS: n = 6'd32;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    return (p == 8'd44) || (p == 8'd83) || (p == 8'd86) || (p == 8'd100) ||
           (p == 8'd110) || (p == 8'd118) || (p == 8'd122) || (p == 8'd244);
  endfunction

endpackage

// ===== src/sps_div.sv =====
// ----------------------------------------------------------------------------
// SPS frame rate divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [32:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[31]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = 33'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = 5'(cnt_r + 5'd1);
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
endmodule

// ===== src/sps_datapath.sv =====
// ----------------------------------------------------------------------------
// SPS parser datapath
// Bit-serial Exp-Golomb and fixed-length field decoder, syntax walk, captured
// fields and the final size, status and frame rate results.
// ----------------------------------------------------------------------------
module sps_datapath #(
  parameter int UE_MAX_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sps_pkg::ctrl_cmd_t cmd,
  input  logic [7:0]         data_byte,
  output sps_pkg::dp_sts_t   sts,
  output logic [111:0]       result
);
  import sps_pkg::*;

  localparam int LZW = $clog2(UE_MAX_BITS);

  logic [7:0]     byte_r;
  phase_t         phase_r, phase_nxt;
  logic           act_r, act_nxt, suf_r, suf_nxt;
  logic [LZW-1:0] lzc_r, lzc_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic [5:0]     left_r, left_nxt;
  logic [7:0]     lc_r, lc_nxt;
  logic           c444_r, c444_nxt, fmo_r, fmo_nxt;
  logic [12:0]    wmb_r, wmb_nxt, hmu_r, hmu_nxt;
  logic [16:0]    cx_r, cx_nxt, cy_r, cy_nxt;
  logic [31:0]    tpu_r, tpu_nxt, ts_r, ts_nxt;
  logic [7:0]     prof_r, prof_nxt, lvl_r, lvl_nxt, refs_r, refs_nxt;
  logic [4:0]     id_r, id_nxt;
  logic [15:0]    sarw_r, sarw_nxt, sarh_r, sarh_nxt;
  logic [2:0]     err_r, err_nxt;
  logic [2:0]     stat_r;
  logic [15:0]    picw_r, pich_r;

  logic           b, fin, fail;
  logic [2:0]     fail_code;
  logic [5:0]     n;
  logic [LZW-1:0] lzc_c;
  logic [31:0]    acc_c, acc_sh, v;
  logic [5:0]     left_c, left_dec;
  logic           suf_c;
  logic [LZW:0]   lzc_inc;
  logic [32:0]    crop_in, crop_sum;
  logic [16:0]    crop_sat;
  logic [16:0]    full_w;
  logic [17:0]    full_h, twice_cx, twice_cy;
  logic [2:0]     stat_c;
  logic           div_busy;
  logic [31:0]    quotient;
  logic [15:0]    fps;

  always_comb begin
    b        = byte_r[cmd.bit_idx];
    n        = elem_bits(phase_r);
    lzc_c    = act_r ? lzc_r : '0;
    acc_c    = act_r ? acc_r : '0;
    left_c   = act_r ? left_r : n;
    suf_c    = act_r ? suf_r : 1'b0;
    acc_sh   = {acc_c[30:0], b};
    left_dec = 6'(left_c - 6'd1);
    lzc_inc  = (LZW+1)'({1'b0, lzc_c} + 1'b1);
    fin      = 1'b0;
    fail     = 1'b0;
    fail_code = ST_RANGE;
    v        = '0;
    crop_in  = '0;

    phase_nxt = phase_r;
    act_nxt = act_r; suf_nxt = suf_r; lzc_nxt = lzc_r; acc_nxt = acc_r;
    left_nxt = left_r; lc_nxt = lc_r; c444_nxt = c444_r; fmo_nxt = fmo_r;
    wmb_nxt = wmb_r; hmu_nxt = hmu_r; cx_nxt = cx_r; cy_nxt = cy_r;
    tpu_nxt = tpu_r; ts_nxt = ts_r; prof_nxt = prof_r; lvl_nxt = lvl_r;
    refs_nxt = refs_r; id_nxt = id_r; sarw_nxt = sarw_r; sarh_nxt = sarh_r;
    err_nxt = err_r;

    if (cmd.bit_en && (phase_r != P_DONE)) begin
      act_nxt  = 1'b1;
      suf_nxt  = suf_c;
      lzc_nxt  = lzc_c;
      acc_nxt  = acc_c;
      left_nxt = left_c;
      if ((n != 6'd0) || suf_c) begin
        acc_nxt  = acc_sh;
        left_nxt = left_dec;
        if (left_dec == 6'd0) begin
          fin = 1'b1;
          v = (n != 6'd0) ? acc_sh : 32'(((32'd1 << lzc_c) - 32'd1) + acc_sh);
        end
      end else if (!b) begin
        lzc_nxt = lzc_inc[LZW-1:0];
        if (32'(lzc_inc) >= 32'(UE_MAX_BITS)) begin
          fail = 1'b1;
        end
      end else if (lzc_c == '0) begin
        fin = 1'b1;
      end else begin
        suf_nxt  = 1'b1;
        left_nxt = 6'(lzc_c);
      end

      if (fin) begin
        act_nxt = 1'b0;
        unique case (phase_r)
          P_NAL: begin
            if (v[4:0] != NAL_TYPE_SPS[4:0]) begin
              fail = 1'b1;
              fail_code = ST_NOT_SPS;
            end
            phase_nxt = P_PROFILE;
          end
          P_PROFILE: begin prof_nxt = v[7:0]; phase_nxt = P_CONSTR; end
          P_CONSTR: phase_nxt = P_LEVEL;
          P_LEVEL: begin lvl_nxt = v[7:0]; phase_nxt = P_ID; end
          P_ID: begin
            if (v > 32'd31) fail = 1'b1;
            id_nxt = v[4:0];
            phase_nxt = high_profile(prof_r) ? P_CHROMA : P_LOG2_FN;
          end
          P_CHROMA: begin
            if (v > 32'd3) fail = 1'b1;
            c444_nxt = (v == 32'd3);
            phase_nxt = (v == 32'd3) ? P_SEPPLANE : P_LUMA_BD;
          end
          P_SEPPLANE: phase_nxt = P_LUMA_BD;
          P_LUMA_BD: begin
            if (v > 32'd6) fail = 1'b1;
            phase_nxt = P_CHROMA_BD;
          end
          P_CHROMA_BD: begin
            if (v > 32'd6) fail = 1'b1;
            phase_nxt = P_BYPASS;
          end
          P_BYPASS: phase_nxt = P_SCAL_PRESENT;
          P_SCAL_PRESENT: begin
            if (v != '0) begin
              lc_nxt = c444_r ? 8'd12 : 8'd8;
              phase_nxt = P_SCAL_FLAG;
            end else begin
              phase_nxt = P_LOG2_FN;
            end
          end
          P_SCAL_FLAG: begin
            if (v != '0) begin
              fail = 1'b1;
              fail_code = ST_SCALING;
            end
            lc_nxt = 8'(lc_r - 8'd1);
            phase_nxt = (lc_r == 8'd1) ? P_LOG2_FN : P_SCAL_FLAG;
          end
          P_LOG2_FN: begin
            if (v > 32'd12) fail = 1'b1;
            phase_nxt = P_POC_TYPE;
          end
          P_POC_TYPE: begin
            if (v > 32'd2) fail = 1'b1;
            phase_nxt = (v == 32'd0) ? P_LOG2_POC :
                        ((v == 32'd1) ? P_DELTA_ZERO : P_MAX_REF);
          end
          P_LOG2_POC: begin
            if (v > 32'd12) fail = 1'b1;
            phase_nxt = P_MAX_REF;
          end
          P_DELTA_ZERO: phase_nxt = P_OFF_NONREF;
          P_OFF_NONREF: phase_nxt = P_OFF_TB;
          P_OFF_TB: phase_nxt = P_NUM_CYCLE;
          P_NUM_CYCLE: begin
            if (v > 32'd255) fail = 1'b1;
            lc_nxt = v[7:0];
            phase_nxt = (v == 32'd0) ? P_MAX_REF : P_CYCLE_OFF;
          end
          P_CYCLE_OFF: begin
            lc_nxt = 8'(lc_r - 8'd1);
            phase_nxt = (lc_r == 8'd1) ? P_MAX_REF : P_CYCLE_OFF;
          end
          P_MAX_REF: begin
            if (v > 32'd255) fail = 1'b1;
            refs_nxt = v[7:0];
            phase_nxt = P_GAPS;
          end
          P_GAPS: phase_nxt = P_WIDTH;
          P_WIDTH: begin
            if (v > 32'd4095) fail = 1'b1;
            wmb_nxt = 13'(v[11:0] + 13'd1);
            phase_nxt = P_HEIGHT;
          end
          P_HEIGHT: begin
            if (v > 32'd4095) fail = 1'b1;
            hmu_nxt = 13'(v[11:0] + 13'd1);
            phase_nxt = P_FRAME_MBS;
          end
          P_FRAME_MBS: begin
            fmo_nxt = (v != '0);
            if ((v == '0) && (hmu_r > 13'd2048)) fail = 1'b1;
            phase_nxt = (v != '0) ? P_DIRECT8 : P_MBAFF;
          end
          P_MBAFF: phase_nxt = P_DIRECT8;
          P_DIRECT8: phase_nxt = P_CROP_FLAG;
          P_CROP_FLAG: phase_nxt = (v != '0) ? P_CROP_L : P_VUI;
          P_CROP_L: begin crop_in = {16'd0, cx_r}; phase_nxt = P_CROP_R; end
          P_CROP_R: begin crop_in = {16'd0, cx_r}; phase_nxt = P_CROP_T; end
          P_CROP_T: begin crop_in = {16'd0, cy_r}; phase_nxt = P_CROP_B; end
          P_CROP_B: begin crop_in = {16'd0, cy_r}; phase_nxt = P_VUI; end
          P_VUI: phase_nxt = (v != '0) ? P_AR_PRESENT : P_DONE;
          P_AR_PRESENT: phase_nxt = (v != '0) ? P_AR_IDC : P_OVERSCAN;
          P_AR_IDC: phase_nxt = (v[7:0] == AR_EXTENDED) ? P_SAR_W : P_OVERSCAN;
          P_SAR_W: begin sarw_nxt = v[15:0]; phase_nxt = P_SAR_H; end
          P_SAR_H: begin sarh_nxt = v[15:0]; phase_nxt = P_OVERSCAN; end
          P_OVERSCAN: phase_nxt = (v != '0) ? P_OVERSCAN_APP : P_VSIG;
          P_OVERSCAN_APP: phase_nxt = P_VSIG;
          P_VSIG: phase_nxt = (v != '0) ? P_VFORMAT : P_CHROMA_LOC;
          P_VFORMAT: phase_nxt = P_FULLRANGE;
          P_FULLRANGE: phase_nxt = P_COLDESC;
          P_COLDESC: phase_nxt = (v != '0) ? P_COLOUR : P_CHROMA_LOC;
          P_COLOUR: phase_nxt = P_CHROMA_LOC;
          P_CHROMA_LOC: phase_nxt = (v != '0) ? P_LOC_TOP : P_TIMING;
          P_LOC_TOP: phase_nxt = P_LOC_BOT;
          P_LOC_BOT: phase_nxt = P_TIMING;
          P_TIMING: phase_nxt = (v != '0) ? P_NUIT : P_DONE;
          P_NUIT: begin tpu_nxt = v; phase_nxt = P_TS; end
          P_TS: begin ts_nxt = v; phase_nxt = P_FIXED; end
          P_FIXED: begin
            if (v == '0) tpu_nxt = '0;
            phase_nxt = P_DONE;
          end
          default: phase_nxt = P_DONE;
        endcase
      end

      if (fail) begin
        err_nxt   = fail_code;
        phase_nxt = P_DONE;
        act_nxt   = 1'b0;
      end
    end

    crop_sum = 33'(crop_in + {1'b0, v});
    crop_sat = (crop_sum > 33'h1FFFF) ? 17'h1FFFF : crop_sum[16:0];
    if (fin && !fail && cmd.bit_en) begin
      if ((phase_r == P_CROP_L) || (phase_r == P_CROP_R)) cx_nxt = crop_sat;
      if ((phase_r == P_CROP_T) || (phase_r == P_CROP_B)) cy_nxt = crop_sat;
    end
  end

  always_comb begin
    full_w   = {wmb_r, 4'd0};
    full_h   = fmo_r ? {1'b0, hmu_r, 4'd0} : {hmu_r, 5'd0};
    twice_cx = {cx_r, 1'b0};
    twice_cy = {cy_r, 1'b0};
    if (err_r != ST_OK) begin
      stat_c = err_r;
    end else if (phase_r != P_DONE) begin
      stat_c = ST_TRUNC;
    end else if ((twice_cx > {1'b0, full_w}) || (twice_cy > full_h)) begin
      stat_c = ST_RANGE;
    end else begin
      stat_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      phase_r <= P_NAL;
      act_r <= 1'b0; suf_r <= 1'b0; lzc_r <= '0; acc_r <= '0; left_r <= '0;
      lc_r <= '0; c444_r <= 1'b0; fmo_r <= 1'b0; wmb_r <= '0; hmu_r <= '0;
      cx_r <= '0; cy_r <= '0; tpu_r <= '0; ts_r <= '0; prof_r <= '0;
      lvl_r <= '0; refs_r <= '0; id_r <= '0; sarw_r <= '0; sarh_r <= '0;
      err_r <= ST_OK;
    end else begin
      phase_r <= phase_nxt;
      act_r <= act_nxt; suf_r <= suf_nxt; lzc_r <= lzc_nxt; acc_r <= acc_nxt;
      left_r <= left_nxt; lc_r <= lc_nxt; c444_r <= c444_nxt; fmo_r <= fmo_nxt;
      wmb_r <= wmb_nxt; hmu_r <= hmu_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
      tpu_r <= tpu_nxt; ts_r <= ts_nxt; prof_r <= prof_nxt; lvl_r <= lvl_nxt;
      refs_r <= refs_nxt; id_r <= id_nxt; sarw_r <= sarw_nxt; sarh_r <= sarh_nxt;
      err_r <= err_nxt;
    end
    if (cmd.load) begin
      byte_r <= data_byte;
    end
    if (cmd.calc) begin
      stat_r <= stat_c;
      picw_r <= 16'({1'b0, full_w} - twice_cx);
      pich_r <= 16'(full_h - twice_cy);
    end
  end

  sps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.calc),
    .dividend (ts_r),
    .divisor  ({tpu_r, 1'b0}),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    if (tpu_r == '0) begin
      fps = '0;
    end else if (quotient > 32'd65535) begin
      fps = 16'hFFFF;
    end else begin
      fps = quotient[15:0];
    end
    if (stat_r == ST_OK) begin
      result = {fps, sarh_r, sarw_r, pich_r, picw_r, refs_r, id_r, lvl_r, prof_r, stat_r};
    end else begin
      result = {109'd0, stat_r};
    end
    sts.div_busy = div_busy;
  end
endmodule

// ===== src/sps_ctrl.sv =====
// ----------------------------------------------------------------------------
// SPS parser controller
// Sequences byte intake, the eight bit steps, the final calculation, the
// frame rate division and the result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  sps_pkg::dp_sts_t   sts,
  output sps_pkg::ctrl_cmd_t cmd
);
  import sps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BITS = 5'b00010,
    S_CALC = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.bit_idx = 3'(3'd7 - cnt_r);
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_tlast;
          cnt_nxt   = '0;
          state_nxt = S_BITS;
        end
      end
      S_BITS: begin
        cmd.bit_en = 1'b1;
        cnt_nxt    = 3'(cnt_r + 3'd1);
        if (cnt_r == 3'd7) begin
          state_nxt = last_r ? S_CALC : S_IDLE;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

  `SPS_ASSERT(a_no_overlap, !(in_tready && out_tvalid), "Intake and result overlap")
  `SPS_ASSERT(a_busy_in_div, sts.div_busy |-> (state_r == S_DIV), "Divider busy outside DIV")
  `SPS_ASSERT(a_accept_bits, (in_tvalid && in_tready) |=> (state_r == S_BITS && cnt_r == 3'd0), "Byte not parsed after accept")
endmodule

// ===== src/h264_sps_header_parser.sv =====
// Sequence: each byte is parsed one bit per cycle; after the last byte come the
// final calculation and the frame rate division before the result is offered.
// Intake: a byte is taken only while the block is idle, after the bits of the previous byte.
// Reset: synchronous active-low rst_n clears the parse state and the controller.
// ----------------------------------------------------------------------------
// H.264 SPS header parser
// Parses an SPS NAL unit bit-serially and reports its main fields on the
// byte marked last.
// ----------------------------------------------------------------------------
module h264_sps_header_parser #(
  parameter int UE_MAX_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, profile_idc, level_idc, sps_id, max_ref_frames, pic_width,
  // pic_height, aspect_width, aspect_height, frame_rate
  output logic [111:0] out_tdata
);
  import sps_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  sps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sps_datapath #(
    .UE_MAX_BITS (UE_MAX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_tdata),
    .sts       (sts),
    .result    (out_tdata)
  );
endmodule
